// File: hw/rtl/tvb_pkg.sv
// Shared types, constants and register indexes for the transformed vertex bounds unit.
// Used by every module under hw/rtl; has no dependencies of its own.
package tvb_pkg;

	// Default vertex coordinate width (signed Q7.8)
	localparam int COORD_BITS_DEF = 16;

	// Result value widths
	localparam int VAL_W  = 24;
	localparam int HALF_W = 23;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [HALF_W-1:0]       half_t;

	localparam val_t  VAL_MAX  = 24'sh7FFFFF;
	localparam val_t  VAL_MIN  = 24'sh800000;
	localparam half_t HALF_MAX = 23'h7FFFFF;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SCALE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TRANSLATION = 3'd5;

	// Volume modes
	localparam logic MODE_BOX      = 1'b0;
	localparam logic MODE_ORIENTED = 1'b1;

	// Fractional bits of the Q3.12 coefficients
	localparam int COEF_FRAC = 12;

	// Register file contents
	typedef struct packed {
		logic             mode;
		logic [2:0][63:0] row;
		logic [47:0]      scale;
		logic [47:0]      trans;
	} cfg_t;

	// Reset values: identity matrix, unit scale, no translation
	localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW_Z_RST = 64'h0000_1000_0000_0000;
	localparam logic [47:0] SCALE_RST = 48'h1000_1000_1000;
	localparam logic [47:0] TRANS_RST = 48'h0;

	// Bounds tracker control
	typedef struct packed {
		logic upd;   // a transformed vertex leaves the transform stage
		logic last;  // that vertex closes the model
	} bnd_ctl_t;

	// Output stream width: nine 24-bit values, three 23-bit values, padded to bytes
	localparam int OUT_BITS    = 9 * VAL_W + 3 * HALF_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

// File: hw/rtl/transformed_vertex_bounds_unit.sv
// Top level of the transformed vertex bounds unit: register file, pipeline control,
// output register. Depends on tvb_pkg, tvb_transform, tvb_bounds and tvb_finish.
//
//  channel   | direction | moves                                  | handshake
//  s_*       | in        | vertex x/y/z in s_tdata, last in tlast | s_tvalid/s_tready
//  m_*       | out       | bounds, center, half widths per model  | m_tvalid/m_tready
//  cfg_*     | in        | register writes by index               | cfg_we
//
// One vertex is taken per cycle unless a closing vertex stalls; the multiply-add per axis
// in the transform stage sets that rate. A result passes the input register, transform
// stage, bounds capture and output register after its last vertex is accepted.
// Reset clears the register file to identity/unit scale and the running bounds.
// With a full output register, input stalls only once a third model closes behind it.
module transformed_vertex_bounds_unit #(
	parameter int COORD_BITS = tvb_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Vertex stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// [vertex_x, vertex_y, vertex_z] from bit 0 up, zero pad to bytes
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,
	input  logic                                    s_tlast,     // last_vertex
	// Result stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// [low_x, low_y, low_z, high_x, high_y, high_z, center_x, center_y, center_z,
	//  half_x, half_y, half_z] from bit 0 up, zero pad to bytes
	output logic [tvb_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// Configuration writes
	input  logic                                    cfg_we,
	input  logic [tvb_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [tvb_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import tvb_pkg::*;

	cfg_t cfg_q;

	logic                         valid_s1, last_s1;
	logic signed [COORD_BITS-1:0] vx_s1, vy_s1, vz_s1;
	logic                         valid_s2, last_s2;
	val_t                         t_s2 [3];
	logic                         valid_s3;

	val_t  t_new [3];
	val_t  lo_s3 [3];
	val_t  hi_s3 [3];
	val_t  center [3];
	half_t half [3];

	logic     out_valid_q;
	val_t     lo_q [3];
	val_t     hi_q [3];
	val_t     center_q [3];
	half_t    half_q [3];

	logic     out_free, s3_free, s3_move, s2_move, s2_free, s1_move, in_acc;
	bnd_ctl_t bnd_ctl;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_BOX;
			cfg_q.row[0] <= ROW_X_RST;
			cfg_q.row[1] <= ROW_Y_RST;
			cfg_q.row[2] <= ROW_Z_RST;
			cfg_q.scale  <= SCALE_RST;
			cfg_q.trans  <= TRANS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOLUME_MODE:     cfg_q.mode   <= cfg_data[0];
				REG_MATRIX_ROW_X:    cfg_q.row[0] <= cfg_data;
				REG_MATRIX_ROW_Y:    cfg_q.row[1] <= cfg_data;
				REG_MATRIX_ROW_Z:    cfg_q.row[2] <= cfg_data;
				REG_AXIS_SCALE:      cfg_q.scale  <= cfg_data[47:0];
				REG_BOX_TRANSLATION: cfg_q.trans  <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// Stage advance: only a closing vertex needs room downstream
	assign out_free = !out_valid_q || m_tready;
	assign s3_move  = valid_s3 && out_free;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_move  = valid_s2 && (!last_s2 || s3_free);
	assign s2_free  = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign in_acc   = s_tvalid && s_tready;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (s2_move) begin
				valid_s2 <= 1'b0;
			end
			if (s2_move && last_s2) begin
				valid_s3 <= 1'b1;
			end else if (s3_move) begin
				valid_s3 <= 1'b0;
			end
			if (s3_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vx_s1   <= s_tdata[COORD_BITS-1:0];
			vy_s1   <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			vz_s1   <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
			last_s1 <= s_tlast;
		end
	end

	tvb_transform #(
		.COORD_BITS(COORD_BITS)
	) u_transform (
		.cfg (cfg_q),
		.vx  (vx_s1),
		.vy  (vy_s1),
		.vz  (vz_s1),
		.t   (t_new)
	);

	// Transform stage register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			t_s2    <= t_new;
			last_s2 <= last_s1;
		end
	end

	assign bnd_ctl.upd  = s2_move;
	assign bnd_ctl.last = last_s2;

	tvb_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bnd_ctl),
		.t      (t_s2),
		.lo_s3  (lo_s3),
		.hi_s3  (hi_s3)
	);

	tvb_finish u_finish (
		.mode   (cfg_q.mode),
		.trans  (cfg_q.trans),
		.lo     (lo_s3),
		.hi     (hi_s3),
		.center (center),
		.half   (half)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (s3_move) begin
			lo_q     <= lo_s3;
			hi_q     <= hi_s3;
			center_q <= center;
			half_q   <= half;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0),
		half_q[2], half_q[1], half_q[0],
		center_q[2], center_q[1], center_q[0],
		hi_q[2], hi_q[1], hi_q[0],
		lo_q[2], lo_q[1], lo_q[0]};

	// A delivered model has seen at least one vertex, so its bounds are ordered
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lo_q[0] <= hi_q[0]) && (lo_q[1] <= hi_q[1]) && (lo_q[2] <= hi_q[2]))
		else $error("result with low above high");

	// A captured model moves into a free output register in the next cycle
	a_capture_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_valid_q |=> out_valid_q)
		else $error("captured bounds not forwarded");

	// Bounds are captured only when a closing vertex leaves the transform stage
	a_capture_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s3) |-> $past(valid_s2 && last_s2))
		else $error("bounds captured without a last vertex");

endmodule

// File: hw/rtl/tvb_transform.sv
// Per-axis vertex transform: 3x4 matrix or per-axis scale, floor to Q.8, saturate.
// Depends on tvb_pkg.
module tvb_transform #(
	parameter int COORD_BITS = tvb_pkg::COORD_BITS_DEF
) (
	input  tvb_pkg::cfg_t                cfg,
	input  logic signed [COORD_BITS-1:0] vx,
	input  logic signed [COORD_BITS-1:0] vy,
	input  logic signed [COORD_BITS-1:0] vz,
	output tvb_pkg::val_t                t [3]
);
	import tvb_pkg::*;

	localparam int PW    = COORD_BITS + 16;
	localparam int ACC_W = (COORD_BITS + 18 > 30) ? COORD_BITS + 18 : 30;
	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-8388608);

	logic signed [COORD_BITS-1:0] v [3];

	assign v[0] = vx;
	assign v[1] = vy;
	assign v[2] = vz;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [15:0]      c0, c1, c2, tr, sc;
		logic signed [PW-1:0]    p0, p1, p2, ps;
		logic signed [ACC_W-1:0] acc, sh;

		// Unpack row coefficients, translation and scale
		assign c0 = cfg.row[a][15:0];
		assign c1 = cfg.row[a][31:16];
		assign c2 = cfg.row[a][47:32];
		assign tr = cfg.row[a][63:48];
		assign sc = cfg.scale[16*a +: 16];

		// Products
		assign p0 = c0 * v[0];
		assign p1 = c1 * v[1];
		assign p2 = c2 * v[2];
		assign ps = sc * v[a];

		// Sum in Q.20 and floor to Q.8
		always_comb begin
			if (cfg.mode == MODE_BOX) begin
				acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + (ACC_W'(tr) <<< COEF_FRAC);
			end else begin
				acc = ACC_W'(ps);
			end
			sh = acc >>> COEF_FRAC;
		end

		// Clamp to the signed 24-bit range
		always_comb begin
			if (sh > ACC_HI) begin
				t[a] = VAL_MAX;
			end else if (sh < ACC_LO) begin
				t[a] = VAL_MIN;
			end else begin
				t[a] = sh[VAL_W-1:0];
			end
		end
	end

endmodule

// File: hw/rtl/tvb_bounds.sv
// Running per-axis minimum and maximum, and the capture register for a finished model.
// Depends on tvb_pkg.
module tvb_bounds (
	input  logic              clk,
	input  logic              arst_n,
	input  tvb_pkg::bnd_ctl_t ctl,
	input  tvb_pkg::val_t     t [3],
	output tvb_pkg::val_t     lo_s3 [3],
	output tvb_pkg::val_t     hi_s3 [3]
);
	import tvb_pkg::*;

	val_t run_min_q [3];
	val_t run_max_q [3];
	val_t new_min [3];
	val_t new_max [3];

	// Fold the incoming vertex into the running bounds
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			new_min[a] = (t[a] < run_min_q[a]) ? t[a] : run_min_q[a];
			new_max[a] = (t[a] > run_max_q[a]) ? t[a] : run_max_q[a];
		end
	end

	// Advance the running bounds; clear them once the model closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				run_min_q[a] <= VAL_MAX;
				run_max_q[a] <= VAL_MIN;
			end
		end else if (ctl.upd) begin
			for (int a = 0; a < 3; a++) begin
				run_min_q[a] <= ctl.last ? VAL_MAX : new_min[a];
				run_max_q[a] <= ctl.last ? VAL_MIN : new_max[a];
			end
		end
	end

	// Hold the final bounds of a model for the finishing stage
	always_ff @(posedge clk) begin
		if (ctl.upd && ctl.last) begin
			for (int a = 0; a < 3; a++) begin
				lo_s3[a] <= new_min[a];
				hi_s3[a] <= new_max[a];
			end
		end
	end

endmodule

// File: hw/rtl/tvb_finish.sv
// Center and half-width computation from the final per-axis bounds.
// Depends on tvb_pkg.
module tvb_finish (
	input  logic           mode,
	input  logic [47:0]    trans,
	input  tvb_pkg::val_t  lo [3],
	input  tvb_pkg::val_t  hi [3],
	output tvb_pkg::val_t  center [3],
	output tvb_pkg::half_t half [3]
);
	import tvb_pkg::*;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [VAL_W:0]   sum;
		logic signed [VAL_W+1:0] cen;
		logic signed [15:0]      tr;
		logic [VAL_W-1:0]        abs_lo, abs_hi;
		logic [VAL_W:0]          abs_sum;
		logic [VAL_W-1:0]        h;

		assign tr = trans[16*a +: 16];

		// Floor midpoint, plus the box position in oriented mode
		always_comb begin
			sum = {lo[a][VAL_W-1], lo[a]} + {hi[a][VAL_W-1], hi[a]};
			cen = {{2{sum[VAL_W]}}, sum[VAL_W:1]};
			if (mode == MODE_ORIENTED) begin
				cen = cen + (VAL_W+2)'(tr);
			end
			if (cen > (VAL_W+2)'(VAL_MAX)) begin
				center[a] = VAL_MAX;
			end else if (cen < (VAL_W+2)'(VAL_MIN)) begin
				center[a] = VAL_MIN;
			end else begin
				center[a] = cen[VAL_W-1:0];
			end
		end

		// Half width from magnitudes; negating the most negative value stays exact unsigned
		always_comb begin
			abs_lo  = lo[a][VAL_W-1] ? (~lo[a] + 1'b1) : lo[a];
			abs_hi  = hi[a][VAL_W-1] ? (~hi[a] + 1'b1) : hi[a];
			abs_sum = {1'b0, abs_lo} + {1'b0, abs_hi};
			h       = abs_sum[VAL_W:1];
			half[a] = h[VAL_W-1] ? HALF_MAX : h[HALF_W-1:0];
		end
	end

endmodule
